// ===== sv/dcf_pkg.sv =====
// Shared types and constants for the DCF77 time code decoder.
`default_nettype none
package dcf_pkg;
  localparam int FrameBits = 59;
  localparam logic [7:0] FltHigh = 8'd97;

  typedef enum logic [1:0] {
    CFG_HYST = 2'd0,
    CFG_ZERO = 2'd1,
    CFG_ONE  = 2'd2,
    CFG_SYNC = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] StatNone  = 2'd0;
  localparam logic [1:0] StatShort = 2'd1;
  localparam logic [1:0] StatFull  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the accepted sample
    logic filt;     // perform one filter step
    logic decide;   // hysteresis, edge and bit handling
    logic align;    // shift the short frame one place left
    logic check;    // validate and latch the frame
    logic out_load; // load the output register
  } dcf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic filt_done;
    logic need_align;
    logic sync;
  } dcf_sts_t;

  function automatic logic bcd_ok(input logic [7:0] x, input logic [3:0] top_hi,
                                  input logic [3:0] top_lo);
    logic [3:0] hi;
    logic [3:0] lo;
    hi = x[7:4];
    lo = x[3:0];
    if (hi > 4'd9 || lo > 4'd9) return 1'b0;
    if (hi > top_hi) return 1'b0;
    if (hi == top_hi && lo > top_lo) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic frame_ok(input logic [63:0] f, input logic short_frame);
    logic [7:0] minute;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [2:0] dow;
    logic ok;
    minute = {1'b0, f[27:21]};
    hour = {2'b0, f[34:29]};
    day = {2'b0, f[41:36]};
    dow = f[44:42];
    month = {3'b0, f[49:45]};
    year = f[57:50];
    ok = 1'b1;
    if (!short_frame && f[0]) ok = 1'b0;
    if (!f[20]) ok = 1'b0;
    if (!short_frame && (f[17] == f[18])) ok = 1'b0;
    if (f[28] != ^minute) ok = 1'b0;
    if (f[35] != ^hour) ok = 1'b0;
    if (f[58] != ^f[57:36]) ok = 1'b0;
    ok = ok && bcd_ok(minute, 4'd5, 4'd9) && bcd_ok(hour, 4'd2, 4'd3)
         && bcd_ok(day, 4'd3, 4'd1) && (day != 8'd0) && (dow != 3'd0)
         && bcd_ok(month, 4'd1, 4'd2) && (month != 8'd0) && bcd_ok(year, 4'd9, 4'd9);
    return ok;
  endfunction
endpackage
`default_nettype wire

// ===== sv/dcf_if.sv =====
// Valid/ready channel interfaces for samples and results.
`default_nettype none
interface dcf_in_if;
  logic        valid;
  logic        ready;
  logic        level;
  logic [15:0] sample_time;
  modport source (output valid, level, sample_time, input ready);
  modport sink (input valid, level, sample_time, output ready);
endinterface

interface dcf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [58:0] frame;
  logic [15:0] phase;
  modport source (output valid, status, frame, phase, input ready);
  modport sink (input valid, status, frame, phase, output ready);
endinterface
`default_nettype wire

// ===== sv/dcf77_time_code_decoder.sv =====
// Top level of the DCF77 time code decoder.
// Samples enter on the in_ channel (level, sample_time), one transfer at a time.
// Each accepted sample yields exactly one result on the out_ channel: status
// (0 none, 1 short frame valid, 2 full frame valid), the latched 59-bit frame
// and the time of the latest accepted sync edge.
// Each sample is loaded, then filtered one step per elapsed tick (ending early
// once the filter stops moving), then decided. At a minute sync, a short frame
// is left-aligned one place per missing bit, and every frame is then checked.
// The filter step unit handles one tick per cycle and sets the throughput.
// A new sample is taken only after the previous result is in the output
// register; the result is held while out_ready is low, and a stalled result
// holds the block in its final state until the transfer completes.
// Reset (rst_n low, synchronous) restores register defaults 64/50/150/1500,
// filter level 64 and clears all frame state.
// Configuration writes on cfg_ take effect at the next clock edge.
`default_nettype none
module dcf77_time_code_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  dcf_in_if.sink           in_ch,
  dcf_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  dcf_pkg::dcf_cmd_t cmd;
  dcf_pkg::dcf_sts_t sts;

  dcf_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  dcf_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_level(in_ch.level), .in_sample_time(in_ch.sample_time),
    .cfg_we, .cfg_index, .cfg_data,
    .out_status(out_ch.status), .out_frame(out_ch.frame), .out_phase(out_ch.phase)
  );
endmodule
`default_nettype wire

// ===== sv/dcf_ctrl.sv =====
// Sequencing controller of the DCF77 decoder.
`default_nettype none
module dcf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire dcf_pkg::dcf_sts_t sts,
  output dcf_pkg::dcf_cmd_t    cmd
);
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FILT   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_ALIGN  = 5'b01000,
    S_CHECK  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   out_free;

  assign out_free  = !ovalid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && !out_ready;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_FILT;
        end
      end
      S_FILT: begin
        if (sts.filt_done) state_nxt = S_DECIDE;
        else cmd.filt = 1'b1;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_ALIGN;
      end
      S_ALIGN: begin
        if (!sts.sync) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            ovalid_nxt   = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (sts.need_align) begin
          cmd.align = 1'b1;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (out_free) begin
          cmd.check    = 1'b1;
          cmd.out_load = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== sv/dcf_dp.sv =====
// Datapath of the DCF77 decoder: filter, hysteresis, bit shifter, frame latch.
`default_nettype none
module dcf_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dcf_pkg::dcf_cmd_t cmd,
  output dcf_pkg::dcf_sts_t      sts,
  input  wire logic              in_level,
  input  wire logic [15:0]       in_sample_time,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  output logic [1:0]             out_status,
  output logic [58:0]            out_frame,
  output logic [15:0]            out_phase
);
  logic [7:0]  hyst_r;
  logic [15:0] zero_th_r, one_th_r, sync_th_r;
  logic [7:0]  flt_r, flt_nxt;
  logic [15:0] ticks_r;
  logic        lvl_r;
  logic [15:0] t_r;
  logic [15:0] last_t_r, last_chg_r, last_edge_r, sync_time_r;
  logic        last_lvl_r, deb_r, sync_r;
  logic [6:0]  bit_cnt_r;
  logic [63:0] shift_r, latch_r;
  logic [1:0]  status_r;
  logic [15:0] chg_now, dt;
  logic [7:0]  margin;
  logic [15:0] hyst_prod;
  logic        rise, fall, edge_hit;
  logic [1:0]  stat_calc;
  logic        short_f;

  assign flt_nxt   = 8'((({8'd0, flt_r} * 16'd124) + (lvl_r ? 16'd512 : 16'd0)) >> 7);
  assign sts.filt_done  = (ticks_r == 16'd0) || (flt_nxt == flt_r);
  assign sts.need_align = (bit_cnt_r < 7'(dcf_pkg::FrameBits));
  assign sts.sync       = sync_r;

  assign chg_now   = (lvl_r != last_lvl_r) ? t_r : last_chg_r;
  assign hyst_prod = 16'(hyst_r) * 16'd97;
  assign margin    = hyst_prod[15:8];
  assign rise      = (flt_r > (dcf_pkg::FltHigh - margin)) && !deb_r;
  assign fall      = (flt_r < margin) && deb_r;
  assign edge_hit  = rise || fall;
  assign dt        = chg_now - last_edge_r;

  // A frame counted short at sync time keeps the relaxed check after alignment.
  assign short_f   = status_r[0];
  assign stat_calc = dcf_pkg::frame_ok(shift_r, short_f)
                     ? (short_f ? dcf_pkg::StatShort : dcf_pkg::StatFull)
                     : dcf_pkg::StatNone;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyst_r <= 8'd64; zero_th_r <= 16'd50; one_th_r <= 16'd150; sync_th_r <= 16'd1500;
      flt_r <= 8'd64; last_t_r <= '0; last_chg_r <= '0; last_lvl_r <= 1'b0;
      deb_r <= 1'b0; last_edge_r <= '0; bit_cnt_r <= '0; shift_r <= '0;
      latch_r <= '0; sync_time_r <= '0; sync_r <= 1'b0; status_r <= '0;
      ticks_r <= '0; lvl_r <= 1'b0; t_r <= '0;
      out_status <= '0; out_frame <= '0; out_phase <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dcf_pkg::CFG_HYST: hyst_r    <= cfg_data[7:0];
          dcf_pkg::CFG_ZERO: zero_th_r <= cfg_data;
          dcf_pkg::CFG_ONE:  one_th_r  <= cfg_data;
          default:           sync_th_r <= cfg_data;
        endcase
      end
      if (cmd.load) begin
        lvl_r   <= in_level;
        t_r     <= in_sample_time;
        ticks_r <= in_sample_time - last_t_r;
        sync_r  <= 1'b0;
      end
      if (cmd.filt) begin
        flt_r   <= flt_nxt;
        ticks_r <= ticks_r - 16'd1;
      end
      if (cmd.decide) begin
        last_chg_r <= chg_now;
        last_t_r   <= t_r;
        last_lvl_r <= lvl_r;
        status_r   <= dcf_pkg::StatNone;
        if (edge_hit) begin
          deb_r       <= rise;
          last_edge_r <= chg_now;
          if (fall) begin
            if (dt > sync_th_r) begin
              sync_r      <= 1'b1;
              sync_time_r <= sync_time_r;
              status_r    <= (bit_cnt_r < 7'(dcf_pkg::FrameBits))
                             ? dcf_pkg::StatShort : dcf_pkg::StatNone;
              t_r         <= chg_now;
            end
          end else if (dt > zero_th_r) begin
            if (dt > one_th_r && !bit_cnt_r[6])
              shift_r <= shift_r | (64'd1 << bit_cnt_r[5:0]);
            if (!bit_cnt_r[6]) bit_cnt_r <= bit_cnt_r + 7'd1;
          end
        end
      end
      if (cmd.align) begin
        shift_r   <= shift_r << 1;
        bit_cnt_r <= bit_cnt_r + 7'd1;
      end
      if (cmd.check) begin
        if (stat_calc != dcf_pkg::StatNone) begin
          latch_r     <= shift_r;
          sync_time_r <= t_r;
        end
        bit_cnt_r <= '0;
        shift_r   <= '0;
      end
      if (cmd.out_load) begin
        out_status <= cmd.check ? stat_calc : dcf_pkg::StatNone;
        out_frame  <= (cmd.check && stat_calc != dcf_pkg::StatNone)
                      ? shift_r[58:0] : latch_r[58:0];
        out_phase  <= (cmd.check && stat_calc != dcf_pkg::StatNone) ? t_r : sync_time_r;
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/dcf77_time_code_decoder_tb.sv =====
// Self-checking testbench for the DCF77 time code decoder: directed frames and random samples.
module dcf77_time_code_decoder_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = dcf_pkg::CFG_HYST;
  logic [15:0] cfg_data = '0;

  dcf_in_if in_ch ();
  dcf_out_if out_ch ();

  dcf77_time_code_decoder i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0]  status;
    logic [58:0] frame;
    logic [15:0] phase;
  } decode_t;

  // Predictor state.
  logic [7:0]  p_hyst;
  logic [15:0] p_zero, p_one, p_sync;
  logic [7:0]  p_flt;
  logic [15:0] p_last_t, p_raw_chg, p_edge_t, p_sync_t;
  logic        p_raw, p_deb;
  logic [6:0]  p_bits;
  logic [63:0] p_shift, p_latch;

  decode_t expected_q[$];
  int unsigned n_fail = 0, n_results = 0, n_valid_frames = 0, n_samples = 0;
  longint unsigned cycles = 0;
  logic [15:0] tnow = 0;

  function automatic logic bcd_good(logic [7:0] x, int th, int tl);
    if (x[7:4] > 9 || x[3:0] > 9) return 1'b0;
    if (x[7:4] > th) return 1'b0;
    if (x[7:4] == th && x[3:0] > tl) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic time_code_valid(logic [63:0] f, logic is_short);
    logic [7:0] mi, hr, dy, mo, yr;
    logic [2:0] dw;
    mi = {1'b0, f[27:21]};
    hr = {2'b0, f[34:29]};
    dy = {2'b0, f[41:36]};
    dw = f[44:42];
    mo = {3'b0, f[49:45]};
    yr = f[57:50];
    if (!is_short && f[0]) return 1'b0;
    if (!f[20]) return 1'b0;
    if (!is_short && f[17] == f[18]) return 1'b0;
    if (f[28] != ^mi[6:0]) return 1'b0;
    if (f[35] != ^hr[5:0]) return 1'b0;
    if (f[58] != ^f[57:36]) return 1'b0;
    return bcd_good(mi, 5, 9) && bcd_good(hr, 2, 3) && bcd_good(dy, 3, 1) && dy != 0
           && dw != 0 && bcd_good(mo, 1, 2) && mo != 0 && bcd_good(yr, 9, 9);
  endfunction

  task automatic decoder_reset_state();
    p_hyst = 8'd64; p_zero = 16'd50; p_one = 16'd150; p_sync = 16'd1500;
    p_flt = 8'd64; p_last_t = 0; p_raw_chg = 0; p_raw = 0; p_deb = 0;
    p_edge_t = 0; p_bits = 0; p_shift = 0; p_latch = 0; p_sync_t = 0;
  endtask

  function automatic decode_t decode_sample(logic lvl, logic [15:0] t);
    logic [15:0] ticks, dt, et;
    logic [7:0] margin, nx;
    logic edge_seen;
    decode_t r;
    ticks = t - p_last_t;
    margin = 8'((16'(p_hyst) * 16'd97) >> 8);
    r.status = dcf_pkg::StatNone;
    edge_seen = 1'b0;
    et = 0;
    for (int i = 0; i < int'(ticks); i++) begin
      nx = 8'((32'(p_flt) * 124 + (lvl ? 512 : 0)) >> 7);
      if (nx == p_flt) break;
      p_flt = nx;
    end
    if (lvl != p_raw) p_raw_chg = t;
    if (p_flt > 8'd97 - margin && !p_deb) begin
      p_deb = 1; edge_seen = 1; et = p_raw_chg;
    end else if (p_flt < margin && p_deb) begin
      p_deb = 0; edge_seen = 1; et = p_raw_chg;
    end
    p_last_t = t;
    p_raw = lvl;
    if (edge_seen) begin
      dt = et - p_edge_t;
      if (!p_deb) begin
        if (dt > p_sync) begin
          if (p_bits < dcf_pkg::FrameBits) begin
            p_shift = p_shift << (dcf_pkg::FrameBits - p_bits);
            if (time_code_valid(p_shift, 1'b1)) r.status = dcf_pkg::StatShort;
          end else if (time_code_valid(p_shift, 1'b0)) r.status = dcf_pkg::StatFull;
          if (r.status != dcf_pkg::StatNone) begin
            p_latch = p_shift; p_sync_t = et;
          end
          p_bits = 0; p_shift = 0;
        end
      end else if (dt > p_zero) begin
        if (dt > p_one && p_bits < 64) p_shift[p_bits[5:0]] = 1'b1;
        if (p_bits < 64) p_bits++;
      end
      p_edge_t = et;
    end
    r.frame = p_latch[58:0];
    r.phase = p_sync_t;
    return r;
  endfunction

  // Result checking; ready is forced high in one phase of a rotating pattern, random elsewhere.
  logic [6:0] stall_pat = 0;
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    decode_t got, want;
    cycles <= cycles + 1;
    stall_pat <= stall_pat + 1;
    out_ch.ready <= (stall_pat[6:5] == 2'b01) ? 1'b1 : ($urandom_range(0, 3) != 0);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.frame, out_ch.phase};
      n_results++;
      if (got.status != dcf_pkg::StatNone) n_valid_frames++;
      if (expected_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch: exp st=%0d fr=%h ph=%h got st=%0d fr=%h ph=%h",
                     want.status, want.frame, want.phase,
                     got.status, got.frame, got.phase);
        end
      end
    end
    if (cycles > 64'd3000000) begin
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Drives one sample and queues the predicted result.
  task automatic send_sample(logic lvl, logic [15:0] t);
    decode_t r;
    in_ch.valid <= 1'b1;
    in_ch.level <= lvl;
    in_ch.sample_time <= t;
    r = decode_sample(lvl, t);
    expected_q.push_back(r);
    do @(posedge clk); while (!in_ch.ready);
    n_samples++;
    tnow = t;
  endtask

  task automatic idle_gap();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic set_reg(dcf_pkg::cfg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dcf_pkg::CFG_HYST: p_hyst = val[7:0];
      dcf_pkg::CFG_ZERO: p_zero = val;
      dcf_pkg::CFG_ONE:  p_one = val;
      default:           p_sync = val;
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Sender with bursts: gap only at the end of a burst.
  int burst_left = 0;
  task automatic paced_sample(logic lvl, logic [15:0] t);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) idle_gap();
    end
    burst_left--;
    send_sample(lvl, t);
  endtask

  // Emits one second: a low pulse, then the high period, two samples per level.
  // The first sample of each level marks the raw change, the second lets the
  // filter settle so the debounced edge is dated at the raw change.
  task automatic send_pulse(int low_len, int high_len);
    paced_sample(1'b0, tnow + 16'd1);
    paced_sample(1'b0, tnow + 16'(low_len - 1));
    paced_sample(1'b1, tnow + 16'd1);
    paced_sample(1'b1, tnow + 16'(high_len - 1));
  endtask

  function automatic logic [58:0] make_code();
    logic [58:0] f;
    f = '0;
    f[16:1] = 16'($urandom);
    f[17] = $urandom_range(0, 1); f[18] = ~f[17];
    f[20] = 1'b1;
    f[24:21] = $urandom_range(0, 9); f[27:25] = $urandom_range(0, 5);
    f[28] = ^f[27:21];
    f[32:29] = $urandom_range(0, 3); f[34:33] = $urandom_range(0, 2);
    f[35] = ^f[34:29];
    f[39:36] = $urandom_range(1, 9); f[41:40] = $urandom_range(0, 2);
    f[44:42] = $urandom_range(1, 7);
    f[48:45] = $urandom_range(1, 9); f[49] = 1'b0;
    f[53:50] = $urandom_range(0, 9); f[57:54] = $urandom_range(0, 9);
    f[58] = ^f[57:36];
    if ($urandom_range(0, 7) == 0) f[$urandom_range(0, 58)] ^= 1'b1;
    return f;
  endfunction

  // Whole minute with default thresholds; short frames drop trailing bits and
  // bits past the end of the code are sent as zeros.
  task automatic send_minute(int nbits);
    logic [58:0] f;
    f = make_code();
    for (int b = 0; b < nbits; b++) begin
      if (b < 59 && f[b]) send_pulse(200, 800);
      else send_pulse(100, 900);
    end
    send_pulse(100, 1900);
    send_pulse(100, 300);
  endtask

  typedef struct {
    logic lvl;
    logic [15:0] t;
  } stim_row_t;

  stim_row_t dir_rows[$];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.level = 1'b0;
    in_ch.sample_time = '0;
    decoder_reset_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: time extremes, wrap, zero elapsed, level toggles.
    dir_rows = '{'{1'b0, 16'd0}, '{1'b1, 16'd0}, '{1'b1, 16'd1}, '{1'b1, 16'd200},
                 '{1'b0, 16'd300}, '{1'b0, 16'hFFFF}, '{1'b1, 16'd5}, '{1'b0, 16'd4},
                 '{1'b1, 16'h8000}, '{1'b1, 16'h7FFF}, '{1'b0, 16'hFFFE},
                 '{1'b1, 16'h0100}, '{1'b0, 16'h0400}};
    // The first sample right after reset sees zero ticks: known result.
    send_sample(dir_rows[0].lvl, dir_rows[0].t);
    if (expected_q[$] !== decode_t'('0)) begin
      n_fail++;
      if (n_fail <= 10) $display("mismatch: exp %h got %h", decode_t'('0), expected_q[$]);
    end
    foreach (dir_rows[i]) if (i > 0) send_sample(dir_rows[i].lvl, dir_rows[i].t);
    drain();

    // A sync to flush earlier bits, then full, short and overlong frames.
    send_pulse(100, 1900);
    send_minute(59);
    send_minute(40);
    send_minute(70);
    drain();

    // Register extremes, random and default settings, each followed by random traffic.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin set_reg(dcf_pkg::CFG_HYST, 16'd255); set_reg(dcf_pkg::CFG_ZERO, 16'd0);
                 set_reg(dcf_pkg::CFG_ONE, 16'hFFFF); set_reg(dcf_pkg::CFG_SYNC, 16'd0); end
        1: begin set_reg(dcf_pkg::CFG_HYST, 16'd0); set_reg(dcf_pkg::CFG_ZERO, 16'hFFFF);
                 set_reg(dcf_pkg::CFG_ONE, 16'd0); set_reg(dcf_pkg::CFG_SYNC, 16'hFFFF); end
        2: begin set_reg(dcf_pkg::CFG_HYST, 16'($urandom_range(0, 255)));
                 set_reg(dcf_pkg::CFG_ZERO, 16'($urandom));
                 set_reg(dcf_pkg::CFG_ONE, 16'($urandom));
                 set_reg(dcf_pkg::CFG_SYNC, 16'($urandom)); end
        default: begin set_reg(dcf_pkg::CFG_HYST, 16'd64); set_reg(dcf_pkg::CFG_ZERO, 16'd50);
                 set_reg(dcf_pkg::CFG_ONE, 16'd150); set_reg(dcf_pkg::CFG_SYNC, 16'd1500); end
      endcase
      for (int k = 0; k < 40; k++) begin
        if ($urandom_range(0, 9) == 0)
          paced_sample(1'($urandom_range(0, 1)), 16'($urandom));
        else
          paced_sample(1'($urandom_range(0, 1)), tnow + 16'($urandom_range(0, 120)));
      end
      drain();
    end

    $display("Covered %0d samples, %0d results, %0d valid frames latched.",
             n_samples, n_results, n_valid_frames);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/dcf_pkg.sv
sv/dcf_if.sv
sv/dcf_ctrl.sv
sv/dcf_dp.sv
sv/dcf77_time_code_decoder.sv
tb/dcf77_time_code_decoder_tb.sv
